// ===== hw/rtl/frw_pkg.sv =====
`default_nettype none

package frw_pkg;

  // Default values for the top level parameters.
  localparam int STORE_DEPTH_DEF = 64;
  localparam int MIN_FRAME_DEF   = 6;
  localparam int STOP_OFFSET_DEF = 5;
  localparam int SENDER_POS_DEF  = 0;
  localparam int LENGTH_POS_DEF  = 2;

  // Fixed field and register widths.
  localparam int CMD_W        = 2;
  localparam int BYTE_W       = 8;
  localparam int TICK_W       = 16;
  localparam int BYTE_COUNT_W = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_SERVICE = 2'd2,
    CMD_FLUSH   = 2'd3
  } command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_SENDER = 2'd0,
    CFG_STOP_VALUE      = 2'd1,
    CFG_TICK_PERIOD     = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_SND,
    ST_RD_LEN,
    ST_RD_STOP,
    ST_CHECK,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE   = 2'd0,
    RD_SENDER = 2'd1,
    RD_LENGTH = 2'd2,
    RD_STOP   = 2'd3
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    wr_byte;
    logic    tick;
    logic    service;
    logic    sweep_clear;
    logic    flush_end;
    rd_sel_t rd_sel;
    logic    cap_sender;
    logic    cap_length;
    logic    check;
    logic    load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pending;
    logic wi_zero;
    logic sweep_at_end;
    logic sweep_at_top;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uart_frame_receiver_watchdog.sv =====
// Frame receiver with watchdog for one receive channel.
// Input channel (in_valid / in_stall): each request carries a 2-bit command
// (received byte, tick, service pending timeout, flush) and the received byte.
// Result channel (out_valid / out_stall): exactly one result per request with
// frame_ready, complete_now, timeout_nack and the write index (byte_count).
// Configuration (cfg_we / cfg_index / cfg_wdata) sets the expected sender id,
// the stop value and the tick period; write it only while the block is idle.
// A received byte takes one write and three reads of the frame store through
// its single read port (sender, length, then the stop byte addressed from the
// length) before its completion check; a tick, or a service with nothing
// pending, goes straight to the result. A flush or a drained timeout clears
// the written entries one per cycle, if there are any, before its result.
// One request is in work at a time and the next one is taken in the cycle
// after the result is loaded.
// After reset the store is cleared in a pass over all STORE_DEPTH entries while
// in_stall stays high; configuration writes are taken during that pass.
// When the receiver stalls, the finished result waits in the output register;
// a new request may be accepted meanwhile, and its result waits until the
// output register is free.
`default_nettype none

module uart_frame_receiver_watchdog #(
  parameter int STORE_DEPTH = frw_pkg::STORE_DEPTH_DEF,
  parameter int MIN_FRAME   = frw_pkg::MIN_FRAME_DEF,
  parameter int STOP_OFFSET = frw_pkg::STOP_OFFSET_DEF,
  parameter int SENDER_POS  = frw_pkg::SENDER_POS_DEF,
  parameter int LENGTH_POS  = frw_pkg::LENGTH_POS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [frw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [frw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [frw_pkg::CMD_W-1:0]       in_command,
  input  wire logic [frw_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_frame_ready,
  output logic                                 out_complete_now,
  output logic                                 out_timeout_nack,
  output logic [frw_pkg::BYTE_COUNT_W-1:0]     out_byte_count
);

  frw_pkg::dp_cmd_t    cmd;
  frw_pkg::dp_status_t status;

  // The controller sequences each request: it accepts in the idle state, then
  // steps through the store reads of the completion check or the clearing
  // sweep, and finally hands the result to the output register.
  frw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the frame store, the index, ready and timeout state,
  // the tick counter, the configuration registers and the output register.
  frw_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .MIN_FRAME   (MIN_FRAME),
    .STOP_OFFSET (STOP_OFFSET),
    .SENDER_POS  (SENDER_POS),
    .LENGTH_POS  (LENGTH_POS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_rx_byte       (in_rx_byte),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_frame_ready  (out_frame_ready),
    .out_complete_now (out_complete_now),
    .out_timeout_nack (out_timeout_nack),
    .out_byte_count   (out_byte_count)
  );

  // Every accepted request keeps the sequencer busy, so the input is stalled in the cycle after the acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while the previous one was still in work");

  // A byte that completes a frame leaves the frame marked ready.
  a_complete_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_complete_now) |-> out_frame_ready)
    else $error("completion reported without frame_ready");

  // A drained timeout flushes the frame.
  a_nack_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_timeout_nack) |-> (!out_frame_ready && (out_byte_count == '0)))
    else $error("timeout NACK without a flushed frame");

  // A result never reports both a completion and a timeout NACK.
  a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_complete_now && out_timeout_nack))
    else $error("completion and timeout NACK in one result");

endmodule

`default_nettype wire

// ===== hw/rtl/frw_ctrl.sv =====
`default_nettype none

module frw_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [frw_pkg::CMD_W-1:0] in_command,
  output logic                          in_stall,
  input  wire frw_pkg::dp_status_t      status,
  output frw_pkg::dp_cmd_t              cmd
);

  frw_pkg::state_t state_r;
  frw_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frw_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      frw_pkg::ST_CLEAR: begin
        cmd.sweep_clear = 1'b1;
        if (status.sweep_at_end) begin
          state_nxt = frw_pkg::ST_IDLE;
        end
      end
      frw_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (frw_pkg::command_t'(in_command))
            frw_pkg::CMD_BYTE: begin
              cmd.wr_byte = 1'b1;
              state_nxt   = frw_pkg::ST_RD_SND;
            end
            frw_pkg::CMD_TICK: begin
              cmd.tick  = 1'b1;
              state_nxt = frw_pkg::ST_DONE;
            end
            frw_pkg::CMD_SERVICE: begin
              cmd.service = 1'b1;
              if (!status.pending) begin
                state_nxt = frw_pkg::ST_DONE;
              end else if (status.wi_zero) begin
                cmd.flush_end = 1'b1;
                state_nxt     = frw_pkg::ST_DONE;
              end else begin
                state_nxt = frw_pkg::ST_FLUSH;
              end
            end
            frw_pkg::CMD_FLUSH: begin
              if (status.wi_zero) begin
                cmd.flush_end = 1'b1;
                state_nxt     = frw_pkg::ST_DONE;
              end else begin
                state_nxt = frw_pkg::ST_FLUSH;
              end
            end
          endcase
        end
      end
      frw_pkg::ST_RD_SND: begin
        cmd.rd_sel = frw_pkg::RD_SENDER;
        state_nxt  = frw_pkg::ST_RD_LEN;
      end
      frw_pkg::ST_RD_LEN: begin
        cmd.cap_sender = 1'b1;
        cmd.rd_sel     = frw_pkg::RD_LENGTH;
        state_nxt      = frw_pkg::ST_RD_STOP;
      end
      frw_pkg::ST_RD_STOP: begin
        cmd.cap_length = 1'b1;
        cmd.rd_sel     = frw_pkg::RD_STOP;
        state_nxt      = frw_pkg::ST_CHECK;
      end
      frw_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = frw_pkg::ST_DONE;
      end
      frw_pkg::ST_FLUSH: begin
        cmd.sweep_clear = 1'b1;
        if (status.sweep_at_top) begin
          cmd.flush_end = 1'b1;
          state_nxt     = frw_pkg::ST_DONE;
        end
      end
      frw_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = frw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = frw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/frw_dp.sv =====
`default_nettype none

module frw_dp #(
  parameter int STORE_DEPTH = frw_pkg::STORE_DEPTH_DEF,
  parameter int MIN_FRAME   = frw_pkg::MIN_FRAME_DEF,
  parameter int STOP_OFFSET = frw_pkg::STOP_OFFSET_DEF,
  parameter int SENDER_POS  = frw_pkg::SENDER_POS_DEF,
  parameter int LENGTH_POS  = frw_pkg::LENGTH_POS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [frw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [frw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [frw_pkg::BYTE_W-1:0]      in_rx_byte,
  input  wire logic                            out_stall,
  input  wire frw_pkg::dp_cmd_t                cmd,
  output frw_pkg::dp_status_t                  status,
  output logic                                 out_valid,
  output logic                                 out_frame_ready,
  output logic                                 out_complete_now,
  output logic                                 out_timeout_nack,
  output logic [frw_pkg::BYTE_COUNT_W-1:0]     out_byte_count
);

  localparam int IDX_W   = $clog2(STORE_DEPTH);
  localparam int MAX_SUM = STOP_OFFSET + (1 << frw_pkg::BYTE_W) - 1;
  localparam int SUM_W   = $clog2(((STORE_DEPTH > MAX_SUM) ? STORE_DEPTH : MAX_SUM) + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

  logic [frw_pkg::BYTE_W-1:0] mem [STORE_DEPTH];

  logic [frw_pkg::BYTE_W-1:0] expected_r;
  logic [frw_pkg::BYTE_W-1:0] stop_value_r;
  logic [frw_pkg::TICK_W-1:0] period_r;

  logic [IDX_W-1:0]           wi_r, wi_nxt, wi_inc;
  logic [IDX_W-1:0]           sweep_r, sweep_nxt;
  logic                       ready_r, ready_nxt;
  logic                       pend_r, pend_nxt;
  logic [frw_pkg::TICK_W-1:0] tick_r, tick_nxt, tick_sum;
  logic                       complete_r, complete_nxt;
  logic                       nack_r, nack_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [frw_pkg::BYTE_W-1:0] rdata_r;
  logic                       sender_ok_r;
  logic                       in_range_r;
  logic [SUM_W-1:0]           stop_sum;
  logic                       hit;

  logic                       mem_we, mem_re;
  logic [IDX_W-1:0]           mem_waddr, mem_raddr;
  logic [frw_pkg::BYTE_W-1:0] mem_wdata;

  logic                              out_frame_ready_r;
  logic                              out_complete_now_r;
  logic                              out_timeout_nack_r;
  logic [frw_pkg::BYTE_COUNT_W-1:0]  out_byte_count_r;

  // Frame store: one write port, one registered read port.
  always_comb begin
    mem_we    = cmd.sweep_clear | cmd.wr_byte;
    mem_waddr = cmd.sweep_clear ? sweep_r : wi_r;
    mem_wdata = cmd.sweep_clear ? '0 : in_rx_byte;
  end

  assign stop_sum = SUM_W'(STOP_OFFSET) + SUM_W'(rdata_r);

  always_comb begin
    mem_re = (cmd.rd_sel != frw_pkg::RD_NONE);
    unique case (cmd.rd_sel)
      frw_pkg::RD_SENDER: mem_raddr = IDX_W'(SENDER_POS);
      frw_pkg::RD_LENGTH: mem_raddr = IDX_W'(LENGTH_POS);
      frw_pkg::RD_STOP:   mem_raddr = stop_sum[IDX_W-1:0];
      default:            mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign wi_inc   = (wi_r == LAST_IDX) ? '0 : wi_r + 1'b1;
  assign tick_sum = tick_r + 1'b1;
  assign hit      = (32'(wi_r) >= 32'(MIN_FRAME)) && sender_ok_r && in_range_r &&
                    (rdata_r == stop_value_r);

  always_comb begin
    wi_nxt        = wi_r;
    sweep_nxt     = sweep_r;
    ready_nxt     = ready_r;
    pend_nxt      = pend_r;
    tick_nxt      = tick_r;
    complete_nxt  = complete_r;
    nack_nxt      = nack_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (cmd.accept) begin
      complete_nxt = 1'b0;
      nack_nxt     = cmd.service & pend_r;
      sweep_nxt    = '0;
    end
    if (cmd.wr_byte) begin
      wi_nxt = wi_inc;
    end
    if (cmd.tick) begin
      if (tick_sum >= period_r) begin
        tick_nxt = '0;
        if ((wi_r != '0) && !ready_r) begin
          pend_nxt = 1'b1;
        end
      end else begin
        tick_nxt = tick_sum;
      end
    end
    if (cmd.service && pend_r) begin
      pend_nxt = 1'b0;
    end
    if (cmd.sweep_clear) begin
      sweep_nxt = sweep_r + 1'b1;
    end
    if (cmd.flush_end) begin
      wi_nxt    = '0;
      ready_nxt = 1'b0;
    end
    if (cmd.check && hit) begin
      ready_nxt    = 1'b1;
      tick_nxt     = '0;
      complete_nxt = 1'b1;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r         <= '0;
      sweep_r      <= '0;
      ready_r      <= 1'b0;
      pend_r       <= 1'b0;
      tick_r       <= '0;
      complete_r   <= 1'b0;
      nack_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      expected_r   <= '0;
      stop_value_r <= '0;
      period_r     <= frw_pkg::TICK_PERIOD_RST;
    end else begin
      wi_r        <= wi_nxt;
      sweep_r     <= sweep_nxt;
      ready_r     <= ready_nxt;
      pend_r      <= pend_nxt;
      tick_r      <= tick_nxt;
      complete_r  <= complete_nxt;
      nack_r      <= nack_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (frw_pkg::cfg_idx_t'(cfg_index))
          frw_pkg::CFG_EXPECTED_SENDER: expected_r   <= cfg_wdata[frw_pkg::BYTE_W-1:0];
          frw_pkg::CFG_STOP_VALUE:      stop_value_r <= cfg_wdata[frw_pkg::BYTE_W-1:0];
          frw_pkg::CFG_TICK_PERIOD:     period_r     <= cfg_wdata[frw_pkg::TICK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Compare results and output payload carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.cap_sender) begin
      sender_ok_r <= (rdata_r == expected_r);
    end
    if (cmd.cap_length) begin
      in_range_r <= (stop_sum < SUM_W'(STORE_DEPTH));
    end
    if (cmd.load_out) begin
      out_frame_ready_r  <= ready_r;
      out_complete_now_r <= complete_r;
      out_timeout_nack_r <= nack_r;
      out_byte_count_r   <= frw_pkg::BYTE_COUNT_W'(wi_r);
    end
  end

  always_comb begin
    status.pending      = pend_r;
    status.wi_zero      = (wi_r == '0);
    status.sweep_at_end = (sweep_r == LAST_IDX);
    status.sweep_at_top = (sweep_r == wi_r - 1'b1);
    status.out_free     = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_frame_ready  = out_frame_ready_r;
  assign out_complete_now = out_complete_now_r;
  assign out_timeout_nack = out_timeout_nack_r;
  assign out_byte_count   = out_byte_count_r;

endmodule

`default_nettype wire
